@@ rtl/core/bss_pkg.sv @@
package bss_pkg;

    // brew cycle modes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_PREHEAT = 3'd1;
    localparam logic [2:0] MODE_PREINF  = 3'd2;
    localparam logic [2:0] MODE_EXTRACT = 3'd3;
    localparam logic [2:0] MODE_FLUSH   = 3'd4;
    localparam logic [2:0] MODE_FAULT   = 3'd5;

    // command codes carried in tuser
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_SHOT     = 3'd1;
    localparam logic [2:0] CMD_FLUSH    = 3'd2;
    localparam logic [2:0] CMD_STOP     = 3'd3;
    localparam logic [2:0] CMD_CLR      = 3'd4;
    localparam logic [2:0] CMD_CLR_SAFE = 3'd5;

    // fault bit positions
    localparam logic [1:0] FLT_OVERP = 2'd0;
    localparam logic [1:0] FLT_OVERT = 2'd1;
    localparam logic [1:0] FLT_DRY   = 2'd2;
    localparam logic [1:0] FLT_SENS  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_MAX_PRESSURE   = 3'd0;
    localparam logic [2:0] REG_MAX_TEMP       = 3'd1;
    localparam logic [2:0] REG_PREHEAT_TARGET = 3'd2;
    localparam logic [2:0] REG_PREINF_PRESS   = 3'd3;
    localparam logic [2:0] REG_PREINF_MS      = 3'd4;
    localparam logic [2:0] REG_EXTRACT_PRESS  = 3'd5;
    localparam logic [2:0] REG_MAX_SHOT_MS    = 3'd6;
    localparam logic [2:0] REG_FLUSH_MS       = 3'd7;

    localparam int CFG_DATA_W = 24;
    localparam int DUR_W      = 24;

    // flow above this (0.01 ml/s units) counts as water moving
    localparam logic [13:0] FLOW_MIN = 14'd10;
    // preheat runs at full duty below target minus this margin
    localparam logic [15:0] DUTY_MARGIN = 16'd20;
    localparam logic signed [15:0] TEMP_SENS_MIN  = -16'sd9000;
    localparam logic signed [15:0] PRESS_SENS_MIN = -16'sd50;

    typedef struct packed {
        logic [12:0] max_pressure_cbar;
        logic [13:0] max_temp_dc;
        logic [13:0] preheat_target_dc;
        logic [12:0] preinfuse_pressure_cbar;
        logic [23:0] preinfuse_ms;
        logic [12:0] extract_pressure_cbar;
        logic [23:0] max_shot_ms;
        logic [23:0] flush_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        max_pressure_cbar:       13'd1200,
        max_temp_dc:             14'd1100,
        preheat_target_dc:       14'd930,
        preinfuse_pressure_cbar: 13'd300,
        preinfuse_ms:            24'd5000,
        extract_pressure_cbar:   13'd900,
        max_shot_ms:             24'd40000,
        flush_ms:                24'd3000
    };

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] dt_ms;
        logic [13:0] pressure_cbar;
        logic [14:0] temp_dc;
        logic [13:0] flow_cml_s;
        logic        sensors_ok;
    } item_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  faults;
        logic        pump_on;
        logic        heater_on;
        logic        heater_full;
        logic        valve_open;
        logic [12:0] pressure_setpoint;
    } result_t;

endpackage

@@ rtl/core/bss_cfg_regs.sv @@
module bss_cfg_regs
    import bss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_PRESSURE:   cfg_next.max_pressure_cbar       = cfg_data[12:0];
                REG_MAX_TEMP:       cfg_next.max_temp_dc             = cfg_data[13:0];
                REG_PREHEAT_TARGET: cfg_next.preheat_target_dc       = cfg_data[13:0];
                REG_PREINF_PRESS:   cfg_next.preinfuse_pressure_cbar = cfg_data[12:0];
                REG_PREINF_MS:      cfg_next.preinfuse_ms            = cfg_data[23:0];
                REG_EXTRACT_PRESS:  cfg_next.extract_pressure_cbar   = cfg_data[12:0];
                REG_MAX_SHOT_MS:    cfg_next.max_shot_ms             = cfg_data[23:0];
                REG_FLUSH_MS:       cfg_next.flush_ms                = cfg_data[23:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

endmodule

@@ rtl/core/bss_fsm.sv @@
module bss_fsm
    import bss_pkg::*;
#(
    parameter int unsigned DRY_FIRE_MS = 10000,
    parameter int unsigned TIMER_BITS  = 24
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int SW = TIMER_BITS + 1;
    localparam int CW = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;
    localparam logic [CW-1:0] DRY_LIMIT = CW'(DRY_FIRE_MS);

    logic [2:0]            mode_reg, mode_next;
    logic [3:0]            fault_reg, fault_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [TIMER_BITS-1:0] since_reg, since_next;
    logic                  shot_reg, shot_next;
    logic                  flushp_reg, flushp_next;
    logic                  pump_reg, pump_next;
    logic                  heat_reg, heat_next;
    logic                  duty_reg, duty_next;
    logic                  valve_reg, valve_next;

    // sign-extended sensor values and limits for the signed compares
    logic signed [15:0] p16, t16, pmax16, tmax16, target16, duty_lim16;
    logic signed [21:0] p10, t10, plim9, tlim9;
    logic [SW-1:0]         timer_sum, since_sum;
    logic [TIMER_BITS-1:0] timer_sat, since_sat;
    logic                  trip_p, trip_t, trip_s, safe_to_clear;

    assign p16        = {{2{item.pressure_cbar[13]}}, item.pressure_cbar};
    assign t16        = {item.temp_dc[14], item.temp_dc};
    assign pmax16     = {3'b0, cfg.max_pressure_cbar};
    assign tmax16     = {2'b0, cfg.max_temp_dc};
    assign target16   = {2'b0, cfg.preheat_target_dc};
    assign duty_lim16 = target16 - DUTY_MARGIN;

    assign p10   = {{8{item.pressure_cbar[13]}}, item.pressure_cbar} * 22'sd10;
    assign t10   = {{7{item.temp_dc[14]}}, item.temp_dc} * 22'sd10;
    assign plim9 = {9'b0, cfg.max_pressure_cbar} * 22'sd9;
    assign tlim9 = {8'b0, cfg.max_temp_dc} * 22'sd9;

    assign safe_to_clear = (p10 <= plim9) && (t10 <= tlim9) && item.sensors_ok;

    assign timer_sum = SW'(timer_reg) + SW'(item.dt_ms);
    assign since_sum = SW'(since_reg) + SW'(item.dt_ms);
    assign timer_sat = timer_sum[TIMER_BITS] ? '1 : timer_sum[TIMER_BITS-1:0];
    assign since_sat = since_sum[TIMER_BITS] ? '1 : since_sum[TIMER_BITS-1:0];

    assign trip_p = p16 > pmax16;
    assign trip_t = t16 > tmax16;
    assign trip_s = (t16 < TEMP_SENS_MIN) || (p16 < PRESS_SENS_MIN) || !item.sensors_ok;

    always_comb
    begin
        logic dry;
        dry         = 1'b0;
        mode_next   = mode_reg;
        fault_next  = fault_reg;
        timer_next  = timer_reg;
        since_next  = since_reg;
        shot_next   = shot_reg;
        flushp_next = flushp_reg;
        pump_next   = pump_reg;
        heat_next   = heat_reg;
        duty_next   = duty_reg;
        valve_next  = valve_reg;

        case (item.cmd)
            CMD_TICK:
            begin
                timer_next = timer_sat;
                since_next = since_sat;
                if (mode_reg != MODE_FAULT)
                begin
                    if (item.flow_cml_s > FLOW_MIN)
                        since_next = '0;
                    // an earlier trip shuts the heater off before dry fire is checked
                    dry = heat_reg && duty_reg && !trip_p && !trip_t &&
                          (CW'(since_next) > DRY_LIMIT);
                    if (trip_p || trip_t || dry || trip_s)
                    begin
                        fault_next[FLT_OVERP] = fault_reg[FLT_OVERP] | trip_p;
                        fault_next[FLT_OVERT] = fault_reg[FLT_OVERT] | trip_t;
                        fault_next[FLT_DRY]   = fault_reg[FLT_DRY] | dry;
                        fault_next[FLT_SENS]  = fault_reg[FLT_SENS] | trip_s;
                        pump_next  = 1'b0;
                        heat_next  = 1'b0;
                        duty_next  = 1'b0;
                        valve_next = 1'b0;
                        mode_next  = MODE_FAULT;
                        timer_next = '0;
                    end
                end

                case (mode_next)
                    MODE_IDLE:
                    begin
                        pump_next  = 1'b0;
                        heat_next  = 1'b0;
                        valve_next = 1'b0;
                        if (shot_reg)
                        begin
                            shot_next  = 1'b0;
                            mode_next  = MODE_PREHEAT;
                            timer_next = '0;
                            heat_next  = 1'b1;
                        end
                    end
                    MODE_PREHEAT:
                    begin
                        if (t16 >= target16)
                        begin
                            mode_next  = MODE_PREINF;
                            timer_next = '0;
                            pump_next  = 1'b1;
                        end
                        duty_next = t16 < duty_lim16;
                    end
                    MODE_PREINF:
                    begin
                        if (CW'(timer_next) >= CW'(cfg.preinfuse_ms))
                        begin
                            mode_next  = MODE_EXTRACT;
                            timer_next = '0;
                        end
                    end
                    MODE_EXTRACT:
                    begin
                        if (CW'(timer_next) >= CW'(cfg.max_shot_ms))
                        begin
                            mode_next  = MODE_FLUSH;
                            timer_next = '0;
                        end
                    end
                    MODE_FLUSH:
                    begin
                        pump_next  = 1'b0;
                        valve_next = 1'b1;
                        if (CW'(timer_next) >= CW'(cfg.flush_ms))
                        begin
                            valve_next = 1'b0;
                            mode_next  = MODE_IDLE;
                            timer_next = '0;
                        end
                    end
                    MODE_FAULT:
                    begin
                        pump_next  = 1'b0;
                        heat_next  = 1'b0;
                        duty_next  = 1'b0;
                        valve_next = 1'b0;
                    end
                    default:
                    begin
                        mode_next  = MODE_FAULT;
                        timer_next = '0;
                    end
                endcase

                if (flushp_reg)
                begin
                    flushp_next = 1'b0;
                    if (mode_next inside {MODE_EXTRACT, MODE_PREINF})
                    begin
                        mode_next  = MODE_FLUSH;
                        timer_next = '0;
                    end
                end
            end
            CMD_SHOT:
            begin
                if (mode_reg == MODE_IDLE)
                    shot_next = 1'b1;
            end
            CMD_FLUSH:
                flushp_next = 1'b1;
            CMD_STOP:
            begin
                if (mode_reg inside {MODE_EXTRACT, MODE_PREINF})
                begin
                    mode_next  = MODE_FLUSH;
                    timer_next = '0;
                end
                else if (mode_reg == MODE_PREHEAT)
                begin
                    mode_next  = MODE_IDLE;
                    timer_next = '0;
                end
            end
            CMD_CLR:
                fault_next = '0;
            CMD_CLR_SAFE:
            begin
                if (mode_reg == MODE_FAULT && safe_to_clear)
                begin
                    fault_next = '0;
                    mode_next  = MODE_IDLE;
                    timer_next = '0;
                end
            end
            default:
                mode_next = mode_reg;
        endcase
    end

    always_comb
    begin
        result.mode        = mode_next;
        result.faults      = fault_next;
        result.pump_on     = pump_next;
        result.heater_on   = heat_next;
        result.heater_full = duty_next;
        result.valve_open  = valve_next;
        case (mode_next)
            MODE_PREINF:  result.pressure_setpoint = cfg.preinfuse_pressure_cbar;
            MODE_EXTRACT: result.pressure_setpoint = cfg.extract_pressure_cbar;
            default:      result.pressure_setpoint = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            fault_reg  <= '0;
            timer_reg  <= '0;
            since_reg  <= '0;
            shot_reg   <= 1'b0;
            flushp_reg <= 1'b0;
            pump_reg   <= 1'b0;
            heat_reg   <= 1'b0;
            duty_reg   <= 1'b0;
            valve_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            fault_reg  <= fault_next;
            timer_reg  <= timer_next;
            since_reg  <= since_next;
            shot_reg   <= shot_next;
            flushp_reg <= flushp_next;
            pump_reg   <= pump_next;
            heat_reg   <= heat_next;
            duty_reg   <= duty_next;
            valve_reg  <= valve_next;
        end
    end

    // flush drives the valve only after the pump is off
    a_pump_valve_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(pump_reg && valve_reg))
        else $error("pump and flush valve on together");

    a_fault_tick_safe: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.cmd == CMD_TICK && mode_reg == MODE_FAULT
        |=> !pump_reg && !heat_reg && !duty_reg && !valve_reg)
        else $error("actuator left on after tick in fault");

    a_faults_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.cmd != CMD_CLR && item.cmd != CMD_CLR_SAFE
        |=> (fault_reg & $past(fault_reg)) == $past(fault_reg))
        else $error("fault bit dropped without a clear");

    a_timer_cleared_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
        fire && mode_next != mode_reg |=> timer_reg == '0)
        else $error("state timer not cleared on mode change");

endmodule

@@ rtl/core/brew_safety_supervisor.sv @@
// Channel  Dir  Handshake                 Payload
// s        in   s_tvalid / s_tready       tuser: cmd; tdata: dt, pressure, temp, flow, ok
// m        out  m_tvalid / m_tready       tdata: mode, faults, actuators, setpoint
// cfg      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle sustained while m_tready stays high; m_tvalid rises once the item has
// passed the input register and then the mode update into the result register.
// The state update and the result for an item are produced in the same cycle.
// A stall on m holds the result register; the input register still takes one item.
// rst_n clears mode to idle, faults, timers and actuators, and loads register defaults.
// cfg writes are always taken (cfg_ready is tied high).
module brew_safety_supervisor
    import bss_pkg::*;
#(
    parameter int unsigned DRY_FIRE_MS = 10000,
    parameter int unsigned TIMER_BITS  = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,  // dt_ms, pressure_cbar, temp_dc, flow_cml_s, sensors_ok
    input  logic [2:0]            s_tuser,  // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,  // mode, faults, pump_on, heater_on, heater_full,
                                            // valve_open, pressure_setpoint
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res_next;
    result_t out_reg;
    logic    out_valid_reg;
    logic    fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.pressure_setpoint, out_reg.valve_open, out_reg.heater_full,
                       out_reg.heater_on, out_reg.pump_on, out_reg.faults, out_reg.mode};

    bss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bss_fsm #(
        .DRY_FIRE_MS (DRY_FIRE_MS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.cmd           <= s_tuser;
            in_item_reg.dt_ms         <= s_tdata[15:0];
            in_item_reg.pressure_cbar <= s_tdata[29:16];
            in_item_reg.temp_dc       <= s_tdata[44:30];
            in_item_reg.flow_cml_s    <= s_tdata[58:45];
            in_item_reg.sensors_ok    <= s_tdata[59];
        end
        if (fire)
            out_reg <= res_next;
    end

endmodule

@@ bench/brew_cycle_checker.sv @@
module brew_cycle_checker
    import bss_pkg::*;
#(
    parameter int unsigned DRY_FIRE_MS = 10000,
    parameter int unsigned TIMER_BITS  = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [63:0]           s_tdata,
    input  logic [2:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    cfg_t                  regs_now;
    logic [2:0]            mode;
    logic [3:0]            flt;
    logic [TIMER_BITS-1:0] mode_ms;
    logic [TIMER_BITS-1:0] dry_ms;
    logic                  shot_req;
    logic                  flush_req;
    logic                  pump;
    logic                  heat_en;
    logic                  heat_full;
    logic                  valve;
    result_t               status_q[$];
    int                    results_seen;

    task automatic report_mismatch(input string msg);
        $display("%0t: status %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    function automatic logic [TIMER_BITS-1:0] timer_add(input logic [TIMER_BITS-1:0] a,
                                                         input logic [15:0] d);
        logic [TIMER_BITS:0] sum;
        sum = {1'b0, a} + (TIMER_BITS+1)'(d);
        return sum[TIMER_BITS] ? TIMER_MAX : sum[TIMER_BITS-1:0];
    endfunction

    task automatic enter_mode(input logic [2:0] m);
        mode = m;
        mode_ms = '0;
    endtask

    task automatic cut_power();
        pump = 1'b0;
        heat_en = 1'b0;
        heat_full = 1'b0;
        valve = 1'b0;
    endtask

    task automatic trip(input logic [1:0] bit_pos);
        flt[bit_pos] = 1'b1;
        cut_power();
        enter_mode(MODE_FAULT);
    endtask

    task automatic tick_step(input logic [15:0] dt, input int p, input int t,
                             input logic [13:0] flow, input logic ok);
        int target;
        target = int'(regs_now.preheat_target_dc);
        mode_ms = timer_add(mode_ms, dt);
        dry_ms = timer_add(dry_ms, dt);
        // sticky checks are skipped while already in fault
        if (mode != MODE_FAULT)
        begin
            if (p > int'(regs_now.max_pressure_cbar))
                trip(FLT_OVERP);
            if (t > int'(regs_now.max_temp_dc))
                trip(FLT_OVERT);
            if (flow > FLOW_MIN)
                dry_ms = '0;
            if (heat_en && heat_full && dry_ms > DRY_FIRE_MS)
                trip(FLT_DRY);
            if (t < int'(TEMP_SENS_MIN) || p < int'(PRESS_SENS_MIN) || !ok)
                trip(FLT_SENS);
        end
        case (mode)
            MODE_IDLE:
            begin
                pump = 1'b0;
                heat_en = 1'b0;
                valve = 1'b0;
                if (shot_req)
                begin
                    shot_req = 1'b0;
                    enter_mode(MODE_PREHEAT);
                    heat_en = 1'b1;
                end
            end
            MODE_PREHEAT:
            begin
                if (t >= target)
                begin
                    enter_mode(MODE_PREINF);
                    pump = 1'b1;
                end
                heat_full = (t < target - int'(DUTY_MARGIN));
            end
            MODE_PREINF:
            begin
                if (mode_ms >= regs_now.preinfuse_ms)
                    enter_mode(MODE_EXTRACT);
            end
            MODE_EXTRACT:
            begin
                if (mode_ms >= regs_now.max_shot_ms)
                    enter_mode(MODE_FLUSH);
            end
            MODE_FLUSH:
            begin
                pump = 1'b0;
                valve = 1'b1;
                if (mode_ms >= regs_now.flush_ms)
                begin
                    valve = 1'b0;
                    enter_mode(MODE_IDLE);
                end
            end
            MODE_FAULT:
                cut_power();
            default:
                enter_mode(MODE_FAULT);
        endcase
        if (flush_req)
        begin
            flush_req = 1'b0;
            if (mode == MODE_EXTRACT || mode == MODE_PREINF)
                enter_mode(MODE_FLUSH);
        end
    endtask

    task automatic brew_step(input logic [2:0] cmd, input logic [15:0] dt, input int p,
                             input int t, input logic [13:0] flow, input logic ok,
                             output result_t r);
        case (cmd)
            CMD_TICK:
                tick_step(dt, p, t, flow, ok);
            CMD_SHOT:
            begin
                if (mode == MODE_IDLE)
                    shot_req = 1'b1;
            end
            CMD_FLUSH:
                flush_req = 1'b1;
            CMD_STOP:
            begin
                if (mode == MODE_EXTRACT || mode == MODE_PREINF)
                    enter_mode(MODE_FLUSH);
                else if (mode == MODE_PREHEAT)
                    enter_mode(MODE_IDLE);
            end
            CMD_CLR:
                flt = '0;
            CMD_CLR_SAFE:
            begin
                if (mode == MODE_FAULT && ok &&
                    p * 10 <= int'(regs_now.max_pressure_cbar) * 9 &&
                    t * 10 <= int'(regs_now.max_temp_dc) * 9)
                begin
                    flt = '0;
                    enter_mode(MODE_IDLE);
                end
            end
            default:
                ;
        endcase
        r.mode = mode;
        r.faults = flt;
        r.pump_on = pump;
        r.heater_on = heat_en;
        r.heater_full = heat_full;
        r.valve_open = valve;
        if (mode == MODE_PREINF)
            r.pressure_setpoint = regs_now.preinfuse_pressure_cbar;
        else if (mode == MODE_EXTRACT)
            r.pressure_setpoint = regs_now.extract_pressure_cbar;
        else
            r.pressure_setpoint = '0;
    endtask

    task automatic load_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_MAX_PRESSURE:   regs_now.max_pressure_cbar = d[12:0];
            REG_MAX_TEMP:       regs_now.max_temp_dc = d[13:0];
            REG_PREHEAT_TARGET: regs_now.preheat_target_dc = d[13:0];
            REG_PREINF_PRESS:   regs_now.preinfuse_pressure_cbar = d[12:0];
            REG_PREINF_MS:      regs_now.preinfuse_ms = d[23:0];
            REG_EXTRACT_PRESS:  regs_now.extract_pressure_cbar = d[12:0];
            REG_MAX_SHOT_MS:    regs_now.max_shot_ms = d[23:0];
            REG_FLUSH_MS:       regs_now.flush_ms = d[23:0];
            default:            ;
        endcase
    endtask

    // m_tdata: mode[2:0] faults[6:3] pump[7] heater_on[8] heater_full[9] valve[10]
    // setpoint[23:11]
    task automatic check_status(input logic [23:0] d);
        result_t want;
        if (status_q.size() == 0)
        begin
            report_mismatch($sformatf("status %h with nothing expected", d));
            return;
        end
        want = status_q.pop_front();
        if (d[2:0] !== want.mode)
            report_mismatch($sformatf("mode %0d, expected %0d", d[2:0], want.mode));
        if (d[6:3] !== want.faults)
            report_mismatch($sformatf("faults %b, expected %b", d[6:3], want.faults));
        if (d[7] !== want.pump_on)
            report_mismatch($sformatf("pump_on %b, expected %b", d[7], want.pump_on));
        if (d[8] !== want.heater_on)
            report_mismatch($sformatf("heater_on %b, expected %b", d[8], want.heater_on));
        if (d[9] !== want.heater_full)
            report_mismatch($sformatf("heater_full %b, expected %b", d[9],
                                      want.heater_full));
        if (d[10] !== want.valve_open)
            report_mismatch($sformatf("valve_open %b, expected %b", d[10], want.valve_open));
        if (d[23:11] !== want.pressure_setpoint)
            report_mismatch($sformatf("setpoint %0d, expected %0d", d[23:11],
                                      want.pressure_setpoint));
        results_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t r;
        if (!rst_n)
        begin
            regs_now = CFG_RESET;
            mode = MODE_IDLE;
            flt = '0;
            mode_ms = '0;
            dry_ms = '0;
            shot_req = 1'b0;
            flush_req = 1'b0;
            cut_power();
            status_q.delete();
            results_seen = 0;
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            // the result leaving now belongs to an earlier item, so check before predicting
            if (m_tvalid && m_tready)
                check_status(m_tdata);
            if (cfg_valid && cfg_ready)
                load_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
            begin
                brew_step(s_tuser, s_tdata[15:0], int'($signed(s_tdata[29:16])),
                          int'($signed(s_tdata[44:30])), s_tdata[58:45], s_tdata[59], r);
                status_q.push_back(r);
            end
            outstanding <= status_q.size();
        end
    end

endmodule

@@ bench/brew_safety_supervisor_test.sv @@
module brew_safety_supervisor_test;
    import bss_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;   // dt_ms, pressure_cbar, temp_dc, flow_cml_s, sensors_ok
    logic [2:0]            s_tuser;   // cmd
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // mode, faults, pump_on, heater_on, heater_full,
                                      // valve_open, pressure_setpoint
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [2:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   check_errors;
    int   pending;
    int   items_sent;
    int   quiet_cycles;
    int   dt_span;
    bit   calm;
    cfg_t cfg_now;

    brew_safety_supervisor dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    brew_cycle_checker u_check
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(check_errors),
        .outstanding(pending)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready = calm || ($urandom_range(99) >= 27);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [2:0] cmd, input int dt, input int p, input int t,
                             input int flow, input bit ok);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 27)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tuser = cmd;
        s_tdata = {4'b0, ok, flow[13:0], t[14:0], p[13:0], dt[15:0]};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic tick(input int dt, input int p, input int t, input int flow, input bit ok);
        send_item(CMD_TICK, dt, p, t, flow, ok);
    endtask

    function automatic int any_press();
        return int'($urandom_range(0, 6000)) - 1000;
    endfunction

    function automatic int any_temp();
        return int'($urandom_range(0, 20000)) - 10000;
    endfunction

    // readings that pass both the trip checks and clear-if-safe
    function automatic int safe_press();
        int lim;
        lim = int'(cfg_now.max_pressure_cbar) * 9 / 10;
        return int'($urandom_range(0, lim + 50)) - 50;
    endfunction

    function automatic int safe_temp();
        int lim;
        lim = int'(cfg_now.max_temp_dc) * 9 / 10;
        return int'($urandom_range(0, lim + 200)) - 200;
    endfunction

    task automatic request(input logic [2:0] cmd);
        send_item(cmd, $urandom_range(0, 65535), any_press(), any_temp(),
                  $urandom_range(0, 10000), 1'($urandom_range(1)));
    endtask

    task automatic noise_item();
        send_item(3'($urandom_range(CMD_TICK, CMD_CLR_SAFE)), $urandom_range(0, 65535),
                  any_press(), any_temp(), $urandom_range(0, 10000), 1'($urandom_range(1)));
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = value[CFG_DATA_W-1:0];
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_cfg(input cfg_t c);
        cfg_now = c;
        write_reg(REG_MAX_PRESSURE, 32'(c.max_pressure_cbar));
        write_reg(REG_MAX_TEMP, 32'(c.max_temp_dc));
        write_reg(REG_PREHEAT_TARGET, 32'(c.preheat_target_dc));
        write_reg(REG_PREINF_PRESS, 32'(c.preinfuse_pressure_cbar));
        write_reg(REG_PREINF_MS, 32'(c.preinfuse_ms));
        write_reg(REG_EXTRACT_PRESS, 32'(c.extract_pressure_cbar));
        write_reg(REG_MAX_SHOT_MS, 32'(c.max_shot_ms));
        write_reg(REG_FLUSH_MS, 32'(c.flush_ms));
    endtask

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.max_pressure_cbar = 13'($urandom_range(600, 5000));
        c.max_temp_dc = 14'($urandom_range(500, 10000));
        // now and then the target sits above the trip limit
        if ($urandom_range(9) == 0)
            c.preheat_target_dc = 14'($urandom_range(0, 10000));
        else
            c.preheat_target_dc = 14'($urandom_range(0, c.max_temp_dc));
        c.preinfuse_pressure_cbar = 13'($urandom_range(0, 5000));
        c.preinfuse_ms = 24'($urandom_range(0, 6000));
        c.extract_pressure_cbar = 13'($urandom_range(0, 5000));
        c.max_shot_ms = 24'($urandom_range(0, 15000));
        c.flush_ms = 24'($urandom_range(0, 5000));
        return c;
    endfunction

    // block must be empty before a register write; a result leaves through the input and result registers
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic brew_cycle();
        int target;
        int maxt;
        int span;
        int steps;
        int pick;
        target = int'(cfg_now.preheat_target_dc);
        maxt = int'(cfg_now.max_temp_dc);
        span = (maxt > target) ? maxt - target : 0;
        if ($urandom_range(9) < 7)
            send_item(CMD_CLR_SAFE, 0, safe_press(), safe_temp(), 0, 1'b1);
        request(CMD_SHOT);
        tick($urandom_range(0, dt_span), safe_press(), safe_temp(),
             $urandom_range(0, 10000), 1'b1);
        steps = $urandom_range(0, 4);
        repeat (steps)
            tick($urandom_range(0, dt_span), safe_press(),
                 target - 1 - int'($urandom_range(0, 400)), $urandom_range(0, 20), 1'b1);
        tick($urandom_range(0, dt_span), safe_press(), target + int'($urandom_range(0, span)),
             $urandom_range(0, 10000), 1'b1);
        steps = $urandom_range(2, 12);
        repeat (steps)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                request(CMD_FLUSH);
            else if (pick < 9)
                request(CMD_STOP);
            else if (pick < 12)
                request(CMD_CLR);
            else if (pick < 14)
                request(CMD_SHOT);
            else if (pick < 17)
                request(CMD_CLR_SAFE);
            else if (pick < 24)
                noise_item();
            else
                tick($urandom_range(0, dt_span), safe_press(), $urandom_range(0, maxt),
                     $urandom_range(0, 10000), $urandom_range(99) != 0);
        end
    endtask

    task automatic run_cycles(input int goal);
        while (items_sent < goal)
            brew_cycle();
    endtask

    initial
    begin
        cfg_t c;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_TICK;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_PRESSURE;
        cfg_data = '0;
        calm = 1'b0;
        items_sent = 0;
        quiet_cycles = 0;
        dt_span = 2500;
        cfg_now = CFG_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed walk under the reset settings
        tick(0, 0, 200, 0, 1'b1);
        send_item(CMD_CLR, 0, 0, 0, 0, 1'b1);
        send_item(CMD_CLR_SAFE, 0, 0, 0, 0, 1'b1);
        send_item(CMD_FLUSH, 0, 0, 0, 0, 1'b1);
        send_item(CMD_STOP, 0, 0, 0, 0, 1'b1);
        tick(100, 0, 200, 11, 1'b1);                // stale flush request in idle
        send_item(CMD_SHOT, 0, 0, 0, 0, 1'b1);
        tick(65535, 0, 500, 0, 1'b1);               // into preheat
        tick(10, 0, 500, 10, 1'b1);                 // flow at threshold does not count
        tick(10, 0, 600, 0, 1'b1);                  // dry fire
        send_item(CMD_CLR_SAFE, 0, 1080, 990, 0, 1'b1);
        send_item(CMD_SHOT, 0, 0, 0, 0, 1'b1);
        tick(50, 0, 300, 5000, 1'b1);
        send_item(CMD_STOP, 0, 0, 0, 0, 1'b1);      // preheat back to idle
        send_item(CMD_SHOT, 0, 0, 0, 0, 1'b1);
        tick(50, 0, 300, 5000, 1'b1);
        tick(50, 0, 930, 11, 1'b1);                 // target reached
        tick(5000, 0, 930, 500, 1'b1);              // preinfuse ends on equality
        send_item(CMD_FLUSH, 0, 0, 0, 0, 1'b1);
        tick(0, 0, 930, 500, 1'b1);
        tick(3000, 0, 930, 500, 1'b1);
        tick(10, 1201, 500, 500, 1'b1);             // overpressure
        send_item(CMD_CLR_SAFE, 0, 1081, 0, 0, 1'b1);
        send_item(CMD_CLR_SAFE, 0, -1000, -10000, 0, 1'b1);
        tick(65535, 5000, 10000, 10000, 1'b0);      // several trips at once
        send_item(CMD_CLR, 0, 0, 0, 0, 1'b1);
        tick(65535, -1000, -9001, 0, 1'b1);
        send_item(CMD_CLR_SAFE, 0, 0, 0, 0, 1'b0);

        wait_drained();
        apply_cfg(random_cfg());
        run_cycles(330);

        // every limit and duration at zero
        wait_drained();
        c = '0;
        apply_cfg(c);
        dt_span = 200;
        run_cycles(400);

        // largest settings: timers run into saturation during preinfuse
        wait_drained();
        c.max_pressure_cbar = 5000;
        c.max_temp_dc = 10000;
        c.preheat_target_dc = 10000;
        c.preinfuse_pressure_cbar = 5000;
        c.preinfuse_ms = 24'hFFFFFF;
        c.extract_pressure_cbar = 5000;
        c.max_shot_ms = 24'hFFFFFF;
        c.flush_ms = 24'hFFFFFF;
        apply_cfg(c);
        send_item(CMD_CLR_SAFE, 0, 0, 0, 0, 1'b1);
        send_item(CMD_SHOT, 0, 0, 0, 0, 1'b1);
        tick(10, safe_press(), 8000, 5000, 1'b1);
        tick(10, safe_press(), 10000, 0, 1'b1);
        repeat (259)
            tick(65535, safe_press(), safe_temp(), $urandom_range(0, 10), 1'b1);
        request(CMD_FLUSH);
        tick(65535, safe_press(), safe_temp(), 0, 1'b1);
        request(CMD_STOP);
        wait_drained();
        cfg_now.flush_ms = '0;
        write_reg(REG_FLUSH_MS, 0);
        tick(1, safe_press(), safe_temp(), 0, 1'b1);
        send_item(CMD_SHOT, 0, 0, 0, 0, 1'b1);
        tick(1, safe_press(), safe_temp(), 0, 1'b1);
        tick(1, safe_press(), 100, 0, 1'b1);
        tick(1, safe_press(), 100, 0, 1'b1);        // flow timer still saturated
        send_item(CMD_CLR_SAFE, 0, safe_press(), safe_temp(), 0, 1'b1);

        // back-to-back stretch on both sides
        wait_drained();
        apply_cfg(random_cfg());
        dt_span = 4000;
        calm = 1'b1;
        run_cycles(items_sent + 160);
        calm = 1'b0;
        run_cycles(950);

        wait_drained();
        apply_cfg(random_cfg());
        dt_span = 1500;
        run_cycles(1150);

        wait_drained();
        repeat (10) @(posedge clk);
        if (check_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
